// File: hw/rtl/mckd_pkg.sv
package mckd_pkg;

    // Field widths fixed by the interface.
    localparam int unsigned KEY_PORTS = 4;
    localparam int unsigned EVENT_W   = 3;
    localparam int unsigned CFG_W     = 16;
    localparam int unsigned CFG_IDX_W = 2;

    typedef logic [EVENT_W-1:0] t_event;

    // Event codes reported per key.
    localparam t_event EV_NONE   = 3'd0;
    localparam t_event EV_SINGLE = 3'd1;
    localparam t_event EV_DOUBLE = 3'd2;
    localparam t_event EV_TRIPLE = 3'd3;
    localparam t_event EV_LONG   = 3'd4;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_CONFIRM = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWIN    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TWIN    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LPRESS  = 2'd3;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_CONFIRM = 16'd2;
    localparam logic [CFG_W-1:0] RST_DWIN    = 16'd30;
    localparam logic [CFG_W-1:0] RST_TWIN    = 16'd30;
    localparam logic [CFG_W-1:0] RST_LPRESS  = 16'd100;

    // Thresholds shared by every key lane.
    typedef struct packed {
        logic [CFG_W-1:0] confirm_ticks;
        logic [CFG_W-1:0] double_window_ticks;
        logic [CFG_W-1:0] triple_window_ticks;
        logic [CFG_W-1:0] long_press_ticks;
    } t_cfg;

endpackage

// File: hw/rtl/mckd_lane.sv
module mckd_lane
    import mckd_pkg::*;
#(
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_cfg   i_cfg,
    input  logic   i_tick,
    input  logic   i_pressed,
    output t_event o_event
);

    localparam int unsigned CW = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;

    typedef enum logic [5:0] {
        ST_RELEASE = 6'b000001,
        ST_CONFIRM = 6'b000010,
        ST_CLICK   = 6'b000100,
        ST_DOUBLE  = 6'b001000,
        ST_TRIPLE  = 6'b010000,
        ST_LONG    = 6'b100000
    } t_state;

    typedef logic [1:0] t_count;
    localparam t_count CC_NONE = 2'd0;
    localparam t_count CC_ONE  = 2'd1;
    localparam t_count CC_TWO  = 2'd2;

    typedef logic [TIMER_BITS-1:0] t_timer;
    localparam t_timer T_ZERO = '0;
    localparam t_timer T_ONE  = t_timer'(1);

    t_state r_state, n_state;
    t_count r_click, n_click;
    t_timer r_press, n_press;
    t_timer r_double, n_double;
    t_timer r_triple, n_triple;
    t_event r_event, n_event;
    logic   r_level;

    logic [CW-1:0] w_confirm, w_dwin, w_twin, w_lpress;

    assign w_confirm = CW'(i_cfg.confirm_ticks);
    assign w_dwin    = CW'(i_cfg.double_window_ticks);
    assign w_twin    = CW'(i_cfg.triple_window_ticks);
    assign w_lpress  = CW'(i_cfg.long_press_ticks);

    // Event code that a finished press reports for the state it ends in.
    function automatic t_event state_event(input t_state s);
        t_event e;
        case (s)
            ST_CLICK:  e = EV_SINGLE;
            ST_DOUBLE: e = EV_DOUBLE;
            ST_TRIPLE: e = EV_TRIPLE;
            ST_LONG:   e = EV_LONG;
            default:   e = EV_NONE;
        endcase
        return e;
    endfunction

    // One scan tick of the detector, updates applied in a fixed order.
    always_comb begin
        n_state  = r_state;
        n_click  = r_click;
        n_press  = r_press;
        n_double = r_double;
        n_triple = r_triple;
        n_event  = i_pressed ? r_event : EV_NONE;

        // A new press may turn a pending click into a double or triple.
        if (i_pressed && !r_level) begin
            if (n_click == CC_ONE) begin
                if (n_double != T_ZERO && CW'(n_double) <= w_dwin) begin
                    n_click  = CC_TWO;
                    n_press  = T_ZERO;
                    n_double = T_ZERO;
                end
            end else if (n_click == CC_TWO) begin
                if (n_triple != T_ZERO && CW'(n_triple) <= w_dwin) begin
                    n_click  = CC_NONE;
                    n_triple = T_ZERO;
                    n_press  = T_ZERO;
                    n_state  = ST_TRIPLE;
                end
            end
        end

        if (CW'(n_triple) >= w_twin) begin
            n_state = ST_DOUBLE;
        end

        // Window timers run while a click or double click is pending.
        if (n_click == CC_ONE) begin
            if (CW'(n_double) >= w_dwin) begin
                n_click  = CC_NONE;
                n_double = T_ZERO;
            end else begin
                n_double = n_double + T_ONE;
            end
        end else if (n_click == CC_TWO) begin
            if (CW'(n_triple) >= w_twin) begin
                n_click  = CC_NONE;
                n_triple = T_ZERO;
            end else begin
                n_triple = n_triple + T_ONE;
            end
        end

        // Detector state machine.
        unique case (n_state)
            ST_RELEASE: begin
                if (i_pressed) begin
                    n_press = T_ZERO;
                    n_state = ST_CONFIRM;
                end
            end
            ST_CONFIRM: begin
                if (!i_pressed) begin
                    n_press = T_ZERO;
                    n_state = ST_RELEASE;
                end else if (CW'(n_press) >= w_confirm) begin
                    n_click  = CC_ONE;
                    n_double = T_ZERO;
                    n_state  = ST_CLICK;
                end else begin
                    n_press = n_press + T_ONE;
                end
            end
            ST_CLICK, ST_DOUBLE, ST_TRIPLE: begin
                if (!i_pressed) begin
                    if (n_state != ST_CLICK || CW'(n_double) >= w_dwin ||
                        (n_double == T_ZERO && CW'(n_press) >= w_dwin)) begin
                        n_click  = CC_NONE;
                        n_press  = T_ZERO;
                        n_double = T_ZERO;
                        n_event  = state_event(n_state);
                        n_state  = ST_RELEASE;
                    end
                end else if (CW'(n_press) >= w_lpress) begin
                    n_state = ST_LONG;
                end else begin
                    n_press = n_press + T_ONE;
                end
            end
            ST_LONG: begin
                if (!i_pressed) begin
                    n_click  = CC_NONE;
                    n_press  = T_ZERO;
                    n_double = T_ZERO;
                    n_event  = EV_LONG;
                    n_state  = ST_RELEASE;
                end
            end
            default: begin
                n_event = EV_NONE;
                n_state = ST_RELEASE;
            end
        endcase
    end

    // Lane state advances only on an accepted beat.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_RELEASE;
            r_click  <= CC_NONE;
            r_press  <= T_ZERO;
            r_double <= T_ZERO;
            r_triple <= T_ZERO;
            r_event  <= EV_NONE;
            r_level  <= 1'b0;
        end else if (i_tick) begin
            r_state  <= n_state;
            r_click  <= n_click;
            r_press  <= n_press;
            r_double <= n_double;
            r_triple <= n_triple;
            r_event  <= n_event;
            r_level  <= i_pressed;
        end
    end

    assign o_event = r_event;

endmodule

// File: hw/rtl/mckd_merge.sv
module mckd_merge
    import mckd_pkg::*;
#(
    parameter int unsigned KEY_COUNT = 4
) (
    input  t_event                       i_events [KEY_COUNT],
    output logic [KEY_PORTS*EVENT_W-1:0] o_key_events,
    output logic                         o_any_event
);

    localparam int unsigned NOUT = (KEY_COUNT < KEY_PORTS) ? KEY_COUNT : KEY_PORTS;

    // Pack the visible keys and flag an event on any key, hidden ones too.
    always_comb begin
        o_key_events = '0;
        o_any_event  = 1'b0;
        for (int k = 0; k < NOUT; k++) begin
            o_key_events[k*EVENT_W +: EVENT_W] = i_events[k];
        end
        for (int k = 0; k < KEY_COUNT; k++) begin
            if (i_events[k] != EV_NONE) begin
                o_any_event = 1'b1;
            end
        end
    end

endmodule

// File: hw/rtl/multi_click_key_detector_core.sv
// Channel  | Direction | Handshake                 | Payload
// in       | input     | i_in_valid / o_in_stall   | i_key_levels
// out      | output    | o_out_valid / i_out_stall | o_key_events, o_any_event
// cfg      | input     | i_cfg_we                  | i_cfg_index, i_cfg_data
//
// Every key has its own lane; all lanes advance together on each accepted beat,
// so one beat is taken per cycle while the input is not stalled, and its result
// appears on the next cycle. The lane event registers are the output register;
// they hold while the result beat is stalled, and the input stalls only while a
// result is still waiting. Synchronous active-low reset returns every key to
// release, clears all counters and loads the default thresholds.
module multi_click_key_detector_core
    import mckd_pkg::*;
#(
    parameter int unsigned KEY_COUNT  = 4,
    parameter int unsigned TIMER_BITS = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [KEY_PORTS-1:0]         i_key_levels,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [KEY_PORTS*EVENT_W-1:0] o_key_events,
    output logic                         o_any_event,
    input  logic                         i_cfg_we,
    input  logic [CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [CFG_W-1:0]             i_cfg_data
);

    t_cfg   r_cfg;
    logic   r_out_valid;
    logic   w_fire;
    t_event w_events [KEY_COUNT];

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.confirm_ticks       <= RST_CONFIRM;
            r_cfg.double_window_ticks <= RST_DWIN;
            r_cfg.triple_window_ticks <= RST_TWIN;
            r_cfg.long_press_ticks    <= RST_LPRESS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_CONFIRM: r_cfg.confirm_ticks       <= i_cfg_data;
                CFG_DWIN:    r_cfg.double_window_ticks <= i_cfg_data;
                CFG_TWIN:    r_cfg.triple_window_ticks <= i_cfg_data;
                CFG_LPRESS:  r_cfg.long_press_ticks    <= i_cfg_data;
            endcase
        end
    end

    // Handshake: take a beat unless a finished result is held by the sink.
    assign o_in_stall = r_out_valid & i_out_stall;
    assign w_fire     = i_in_valid & ~o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= w_fire | (r_out_valid & i_out_stall);
        end
    end

    assign o_out_valid = r_out_valid;

    // One lane per key; keys without an input bit read as released.
    for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
        logic w_pressed;
        if (k < KEY_PORTS) begin : g_in
            assign w_pressed = i_key_levels[k];
        end else begin : g_none
            assign w_pressed = 1'b0;
        end

        mckd_lane #(
            .TIMER_BITS(TIMER_BITS)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_cfg    (r_cfg),
            .i_tick   (w_fire),
            .i_pressed(w_pressed),
            .o_event  (w_events[k])
        );
    end

    // Combine the lane events into the result beat.
    mckd_merge #(
        .KEY_COUNT(KEY_COUNT)
    ) u_merge (
        .i_events    (w_events),
        .o_key_events(o_key_events),
        .o_any_event (o_any_event)
    );

    // An accepted beat always produces a result on the next cycle.
    a_fire_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |=> o_out_valid)
        else $error("accepted beat produced no result");

    // A visible key event must raise the summary flag.
    a_any_covers_events: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_key_events != '0) |-> o_any_event)
        else $error("key event without any_event");

    // The input is never stalled while no result is pending.
    a_no_idle_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output");

    // Lane state holds while the result beat is stalled.
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_key_events) && $stable(o_any_event))
        else $error("result changed under stall");

endmodule
